FILE: rtl/ssa_pkg.sv
// Slab slot allocator: shared types and codes.
// No dependencies; imported by the allocator top level.
`default_nettype none
package ssa_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SLAB  = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [13:0] {
        S_IDLE       = 14'b00000000000001,
        S_CHK_CACHE  = 14'b00000000000010,
        S_WALK       = 14'b00000000000100,
        S_ACT_SCAN   = 14'b00000000001000,
        S_ACT_LINK   = 14'b00000000010000,
        S_ACT_PREV   = 14'b00000000100000,
        S_THREAD     = 14'b00000001000000,
        S_POP        = 14'b00000010000000,
        S_POP_WB     = 14'b00000100000000,
        S_FREE_CACHE = 14'b00001000000000,
        S_FREE_CHK   = 14'b00010000000000,
        S_UNL_PV     = 14'b00100000000000,
        S_UNL_NX     = 14'b01000000000000,
        S_FINISH     = 14'b10000000000000
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/ssa_link_ram.sv
// Slot link memory: one write port, one read port with registered data.
// No dependencies.
`default_nettype none
module ssa_link_ram #(
    parameter int AW = 7,
    parameter int DW = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [0:(1 << AW) - 1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/slab_slot_allocator_core.sv
// Slab slot allocator top level: sequencer, slab records, output register.
// Depends on ssa_pkg and ssa_link_ram.
// Usage:
//   Input channel (i_valid/o_ready) carries one transaction: allocate
//   (i_mode=0) or free of (i_slab_index, i_slot_index). Each transaction
//   yields exactly one result on the output channel (o_valid/i_ready):
//   o_status, o_granted_slab, o_granted_slot.
//   i_cfg_we/i_cfg_wdata set the slots threaded into a newly activated slab;
//   write only while idle.
// Sequence (accept to result valid, receiver ready):
//   allocate from the cached slab: cache check, pop, pop write-back, finish;
//   otherwise a list walk visits slabs first (up to NUM_SLABS); activating a
//   slab adds a scan of up to NUM_SLABS slabs, a link step, a prev-link
//   step if the list was not empty, and a thread step per slot. Free: cache
//   check, check and write, finish, plus unlink steps when a slab retires.
// One transaction in flight; o_ready is high only when the sequencer is idle.
// Reset: synchronous, active low; all slabs unused, empty list, no cache.
// Receiver stall: the result sits in the output register; a new transaction
// can be accepted and worked on, and it waits at its end until the
// register is free.
`default_nettype none
module slab_slot_allocator_core #(
    parameter int NUM_SLABS = 8,
    parameter int MAX_SLOTS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_mode,
    input  wire logic [2:0] i_slab_index,
    input  wire logic [3:0] i_slot_index,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_status,
    output logic [2:0]      o_granted_slab,
    output logic [3:0]      o_granted_slot,
    input  wire logic       i_cfg_we,
    input  wire logic [4:0] i_cfg_wdata
);
    import ssa_pkg::*;

    localparam int SW = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
    localparam int LW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int EW = (CW > 5) ? CW : 5;
    localparam int BW = (SW > 3) ? SW + 1 : 4;
    localparam logic [SW-1:0] LAST_SLAB = SW'(NUM_SLABS - 1);
    localparam logic [4:0]    USED_MAX  = 5'd31;

    t_state         r_state;
    logic [4:0]     r_cfg;
    logic [SW-1:0]  r_ptr;
    logic [SW-1:0]  r_sel;
    logic [SW-1:0]  r_guard;
    logic [LW-1:0]  r_i;
    logic [EW-1:0]  r_n;
    logic           r_mode;
    logic [2:0]     r_sb;
    logic [3:0]     r_sl;
    logic           r_keep;
    logic           r_head_v;
    logic [SW-1:0]  r_head;
    logic           r_cached_v;
    logic [SW-1:0]  r_cached;
    logic           r_nx_v, r_pv_v;
    logic [SW-1:0]  r_nx, r_pv;
    logic [1:0]     r_st;
    logic [SW-1:0]  r_gs;
    logic [LW-1:0]  r_gl;

    logic           r_live  [NUM_SLABS];
    logic           r_nxt_v [NUM_SLABS];
    logic [SW-1:0]  r_nxt   [NUM_SLABS];
    logic           r_prv_v [NUM_SLABS];
    logic [SW-1:0]  r_prv   [NUM_SLABS];
    logic           r_top_v [NUM_SLABS];
    logic [LW-1:0]  r_top   [NUM_SLABS];
    logic [4:0]     r_used  [NUM_SLABS];

    logic [EW-1:0]  cfg_w;
    logic [EW-1:0]  eff;
    logic           mem_we;
    logic [SW+LW-1:0] mem_waddr, mem_raddr;
    logic [LW:0]    mem_wdata, mem_rdata;
    logic           free_bad;
    logic           retire;
    logic           cache_final_v;
    logic [SW-1:0]  cache_final;
    logic [4:0]     used_dec;

    assign cfg_w = EW'(r_cfg);
    always_comb begin
        priority if (r_cfg == 5'd0) begin
            eff = EW'(1);
        end else if (cfg_w > EW'(MAX_SLOTS)) begin
            eff = EW'(MAX_SLOTS);
        end else begin
            eff = cfg_w;
        end
    end

    assign free_bad = (BW'(r_sb) >= BW'(NUM_SLABS)) || !r_live[r_ptr]
                      || (r_used[r_ptr] == 5'd0) || (EW'(r_sl) >= eff);
    assign used_dec = r_used[r_ptr] - 5'd1;
    assign retire   = (used_dec == 5'd0) && (r_nxt_v[r_ptr] || r_prv_v[r_ptr]);
    assign cache_final   = r_keep ? r_cached : r_ptr;
    assign cache_final_v = !(retire && (cache_final == r_ptr));

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {r_ptr, r_i};
        mem_wdata = {1'b0, r_i};
        if (r_state == S_THREAD) begin
            mem_we = 1'b1;
            if ((EW'(r_i) + EW'(1)) < r_n) begin
                mem_wdata = {1'b1, r_i + LW'(1)};
            end
        end else if (r_state == S_FREE_CHK && !free_bad) begin
            mem_we    = 1'b1;
            mem_waddr = {r_ptr, LW'(r_sl)};
            mem_wdata = {r_top_v[r_ptr], r_top[r_ptr]};
        end
    end
    assign mem_raddr = {r_ptr, r_top[r_ptr]};

    ssa_link_ram #(.AW(SW + LW), .DW(LW + 1)) u_link (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cfg      <= 5'd16;
            r_head_v   <= 1'b0;
            r_cached_v <= 1'b0;
            o_valid    <= 1'b0;
            for (int k = 0; k < NUM_SLABS; k++) begin
                r_live[k] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (o_valid && i_ready && r_state != S_FINISH) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode <= i_mode;
                        r_sb   <= i_slab_index;
                        r_sl   <= i_slot_index;
                        r_ptr  <= r_cached;
                        r_st   <= ST_OK;
                        r_gs   <= '0;
                        r_gl   <= '0;
                        r_state <= (i_mode == MODE_FREE) ? S_FREE_CACHE : S_CHK_CACHE;
                    end
                end
                S_CHK_CACHE: begin
                    r_guard <= '0;
                    if (r_cached_v && r_live[r_ptr] && r_top_v[r_ptr]) begin
                        r_state <= S_POP;
                    end else if (r_head_v) begin
                        r_ptr   <= r_head;
                        r_state <= S_WALK;
                    end else begin
                        r_ptr   <= '0;
                        r_state <= S_ACT_SCAN;
                    end
                end
                S_WALK: begin
                    if (r_top_v[r_ptr]) begin
                        r_cached_v <= 1'b1;
                        r_cached   <= r_ptr;
                        r_state    <= S_POP;
                    end else if (!r_nxt_v[r_ptr] || r_guard == LAST_SLAB) begin
                        r_ptr   <= '0;
                        r_state <= S_ACT_SCAN;
                    end else begin
                        r_ptr   <= r_nxt[r_ptr];
                        r_guard <= r_guard + SW'(1);
                    end
                end
                S_ACT_SCAN: begin
                    if (!r_live[r_ptr]) begin
                        r_state <= S_ACT_LINK;
                    end else if (r_ptr == LAST_SLAB) begin
                        r_st    <= ST_NO_SLAB;
                        r_state <= S_FINISH;
                    end else begin
                        r_ptr <= r_ptr + SW'(1);
                    end
                end
                S_ACT_LINK: begin
                    r_live[r_ptr]  <= 1'b1;
                    r_prv_v[r_ptr] <= 1'b0;
                    r_nxt_v[r_ptr] <= r_head_v;
                    r_nxt[r_ptr]   <= r_head;
                    r_used[r_ptr]  <= 5'd0;
                    r_top_v[r_ptr] <= 1'b1;
                    r_top[r_ptr]   <= '0;
                    r_sel    <= r_ptr;
                    r_i      <= '0;
                    r_n      <= eff;
                    r_head_v <= 1'b1;
                    r_head   <= r_ptr;
                    if (r_head_v) begin
                        r_ptr   <= r_head;
                        r_state <= S_ACT_PREV;
                    end else begin
                        r_state <= S_THREAD;
                    end
                end
                S_ACT_PREV: begin
                    r_prv_v[r_ptr] <= 1'b1;
                    r_prv[r_ptr]   <= r_sel;
                    r_ptr          <= r_sel;
                    r_state        <= S_THREAD;
                end
                S_THREAD: begin
                    if ((EW'(r_i) + EW'(1)) >= r_n) begin
                        r_cached_v <= 1'b1;
                        r_cached   <= r_ptr;
                        r_state    <= S_POP;
                    end else begin
                        r_i <= r_i + LW'(1);
                    end
                end
                S_POP: begin
                    r_gs    <= r_ptr;
                    r_gl    <= r_top[r_ptr];
                    r_state <= S_POP_WB;
                end
                S_POP_WB: begin
                    r_top_v[r_ptr] <= mem_rdata[LW];
                    r_top[r_ptr]   <= mem_rdata[LW-1:0];
                    if (r_used[r_ptr] != USED_MAX) begin
                        r_used[r_ptr] <= r_used[r_ptr] + 5'd1;
                    end
                    r_state <= S_FINISH;
                end
                S_FREE_CACHE: begin
                    r_keep  <= r_cached_v && ((r_cached == SW'(r_sb))
                               || (r_live[r_ptr] && r_top_v[r_ptr]));
                    r_ptr   <= SW'(r_sb);
                    r_state <= S_FREE_CHK;
                end
                S_FREE_CHK: begin
                    if (free_bad) begin
                        r_st    <= ST_BAD_FREE;
                        r_state <= S_FINISH;
                    end else begin
                        r_top_v[r_ptr] <= 1'b1;
                        r_top[r_ptr]   <= LW'(r_sl);
                        r_used[r_ptr]  <= used_dec;
                        r_cached_v     <= cache_final_v;
                        r_cached       <= cache_final;
                        r_nx_v <= r_nxt_v[r_ptr];
                        r_nx   <= r_nxt[r_ptr];
                        r_pv_v <= r_prv_v[r_ptr];
                        r_pv   <= r_prv[r_ptr];
                        if (retire) begin
                            r_live[r_ptr] <= 1'b0;
                            if (r_head_v && r_head == r_ptr) begin
                                r_head_v <= r_nxt_v[r_ptr];
                                r_head   <= r_nxt[r_ptr];
                            end
                            r_ptr   <= r_prv[r_ptr];
                            r_state <= S_UNL_PV;
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_UNL_PV: begin
                    if (r_pv_v) begin
                        r_nxt_v[r_ptr] <= r_nx_v;
                        r_nxt[r_ptr]   <= r_nx;
                    end
                    r_ptr   <= r_nx;
                    r_state <= S_UNL_NX;
                end
                S_UNL_NX: begin
                    if (r_nx_v) begin
                        r_prv_v[r_ptr] <= r_pv_v;
                        r_prv[r_ptr]   <= r_pv;
                    end
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!o_valid || i_ready) begin
                        o_valid        <= 1'b1;
                        o_status       <= r_st;
                        o_granted_slab <= 3'(r_gs);
                        o_granted_slot <= 4'(r_gl);
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("sequencer state not one-hot");
    a_head_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_head_v) |-> r_live[r_head])
        else $error("list head is not a live slab");
    a_cache_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_cached_v) |-> r_live[r_cached])
        else $error("cached slab is not live");
    a_thread_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_THREAD) |-> r_live[r_ptr])
        else $error("threading a slab that is not live");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_granted_slab == 3'd0 && o_granted_slot == 4'd0))
        else $error("error result carries a handle");
`endif
endmodule
`default_nettype wire
